// File: src/mbc_pkg.sv
// Shared types and constants for the media playback clock.
// Request and result payload structs, command and run state codes.
// No dependencies.
package mbc_pkg;

  // Default widths handed to the top level parameters
  localparam int TIME_WIDTH_DEF = 64;
  localparam int RATE_WIDTH_DEF = 16;

  // Rate numerator and denominator after reset
  localparam int RATE_RESET = 1000;

  // Command codes
  localparam logic [3:0] CMD_QUERY     = 4'd0;
  localparam logic [3:0] CMD_PLAY      = 4'd1;
  localparam logic [3:0] CMD_PAUSE     = 4'd2;
  localparam logic [3:0] CMD_RESUME    = 4'd3;
  localparam logic [3:0] CMD_STOP      = 4'd4;
  localparam logic [3:0] CMD_SEEK      = 4'd5;
  localparam logic [3:0] CMD_SEEK_DONE = 4'd6;
  localparam logic [3:0] CMD_SET_RATE  = 4'd7;
  localparam logic [3:0] CMD_SET_AUDIO = 4'd8;

  // Run state codes
  localparam logic [1:0] RUN_STOPPED = 2'd0;
  localparam logic [1:0] RUN_PLAYING = 2'd1;
  localparam logic [1:0] RUN_PAUSED  = 2'd2;
  localparam logic [1:0] RUN_SEEKING = 2'd3;

  // Request payload
  typedef struct packed {
    logic [3:0]  cmd;
    logic [62:0] now_usec;
    logic [62:0] seek_target_in;
    logic [15:0] rate_num_in;
    logic [15:0] rate_den_in;
    logic [62:0] audio_frames_in;
  } mbc_req_t;

  // Result payload
  typedef struct packed {
    logic [1:0]         run_state_out;
    logic signed [63:0] media_time_usec;
    logic [62:0]        seek_target_out;
    logic [62:0]        audio_frames_out;
  } mbc_res_t;

endpackage

// File: src/media_playback_clock.sv
// Media playback clock top level: command sequencer, clock state and result register.
// Uses mbc_scale for the rate scaling and mbc_pkg for payload types and codes.
// One request is worked on at a time; most of its work is the bit-serial scaler, with
// RATE_WIDTH multiply steps and 64 + RATE_WIDTH divide steps. A set-rate request while
// playing runs the scaler three times (old-rate media time, re-anchor, new-rate media
// time). A stop or stopped-state request skips the scaler and goes from S_EXEC through
// S_ELAP0 and S_ELAP1 to S_OUT. The next request is taken while a result still waits.
module media_playback_clock #(
  parameter int TIME_WIDTH = mbc_pkg::TIME_WIDTH_DEF,
  parameter int RATE_WIDTH = mbc_pkg::RATE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  mbc_pkg::mbc_req_t cmd_data,
  output logic             res_valid,
  input  logic             res_stall,
  output mbc_pkg::mbc_res_t res_data
);

  localparam int TW = (TIME_WIDTH >= 63) ? 63 : TIME_WIDTH;
  localparam logic [62:0] TMASK = 63'((64'd1 << TW) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RESUME, S_ELAP0, S_ELAP1, S_WAIT_MT, S_WAIT_RA, S_OUT
  } state_t;

  state_t                state;

  // Latched request
  logic [3:0]            r_cmd;
  logic [63:0]           r_now;
  logic [62:0]           r_target;
  logic [62:0]           r_frames;
  logic [RATE_WIDTH-1:0] new_num;
  logic [RATE_WIDTH-1:0] new_den;

  // Clock state
  logic [1:0]            run_state;
  logic [63:0]           epoch;
  logic [63:0]           pause_offset;
  logic [63:0]           pause_mark;
  logic [RATE_WIDTH-1:0] play_num;
  logic [RATE_WIDTH-1:0] play_den;
  logic [62:0]           seek_target;
  logic [62:0]           audio_pos;

  // Scaler operands and working values
  logic                  reanchor;
  logic                  sc_start;
  logic [63:0]           sc_x;
  logic [RATE_WIDTH-1:0] sc_mul;
  logic [RATE_WIDTH-1:0] sc_div;
  logic                  sc_done;
  logic [63:0]           sc_result;
  logic [63:0]           media;

  assign cmd_stall = (state != S_IDLE);

  mbc_scale #(
    .RATE_WIDTH(RATE_WIDTH)
  ) u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (sc_start),
    .x     (sc_x),
    .mul   (sc_mul),
    .div   (sc_div),
    .done  (sc_done),
    .result(sc_result)
  );

  // Sequence each request and hold the clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      sc_start     <= 1'b0;
      reanchor     <= 1'b0;
      run_state    <= mbc_pkg::RUN_STOPPED;
      epoch        <= '0;
      pause_offset <= '0;
      pause_mark   <= '0;
      play_num     <= RATE_WIDTH'(mbc_pkg::RATE_RESET);
      play_den     <= RATE_WIDTH'(mbc_pkg::RATE_RESET);
      seek_target  <= '0;
      audio_pos    <= '0;
    end else begin
      sc_start <= 1'b0;
      // Drop the result once taken
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            r_cmd    <= cmd_data.cmd;
            r_now    <= {1'b0, cmd_data.now_usec & TMASK};
            r_target <= cmd_data.seek_target_in & TMASK;
            r_frames <= cmd_data.audio_frames_in & TMASK;
            new_num  <= RATE_WIDTH'(cmd_data.rate_num_in);
            new_den  <= RATE_WIDTH'(cmd_data.rate_den_in);
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_ELAP0;
          case (r_cmd)
            mbc_pkg::CMD_PLAY: begin
              epoch        <= r_now;
              pause_offset <= '0;
              pause_mark   <= '0;
              audio_pos    <= '0;
              run_state    <= mbc_pkg::RUN_PLAYING;
            end
            mbc_pkg::CMD_PAUSE: begin
              if (run_state == mbc_pkg::RUN_PLAYING) begin
                pause_mark <= r_now;
                run_state  <= mbc_pkg::RUN_PAUSED;
              end
            end
            mbc_pkg::CMD_RESUME: begin
              if (run_state == mbc_pkg::RUN_PAUSED) begin
                sc_x  <= r_now - pause_mark;
                state <= S_RESUME;
              end
            end
            mbc_pkg::CMD_STOP: begin
              run_state <= mbc_pkg::RUN_STOPPED;
            end
            mbc_pkg::CMD_SEEK: begin
              seek_target <= r_target;
              run_state   <= mbc_pkg::RUN_SEEKING;
            end
            mbc_pkg::CMD_SEEK_DONE: begin
              epoch        <= r_now - {1'b0, seek_target};
              pause_offset <= '0;
              run_state    <= mbc_pkg::RUN_PLAYING;
            end
            mbc_pkg::CMD_SET_RATE: begin
              if ((new_num != '0) && (new_den != '0)) begin
                if (run_state == mbc_pkg::RUN_PLAYING) begin
                  reanchor <= 1'b1;
                end else begin
                  play_num <= new_num;
                  play_den <= new_den;
                end
              end
            end
            mbc_pkg::CMD_SET_AUDIO: begin
              audio_pos <= r_frames;
            end
            default: begin
            end
          endcase
        end
        // Fold the pause length into the offset
        S_RESUME: begin
          pause_offset <= pause_offset + sc_x;
          pause_mark   <= '0;
          run_state    <= mbc_pkg::RUN_PLAYING;
          state        <= S_ELAP0;
        end
        // Elapsed time, frozen at pause start while paused
        S_ELAP0: begin
          sc_x  <= ((run_state == mbc_pkg::RUN_PAUSED) ? pause_mark : r_now) - epoch;
          state <= S_ELAP1;
        end
        S_ELAP1: begin
          if (run_state == mbc_pkg::RUN_STOPPED) begin
            media <= '0;
            state <= S_OUT;
          end else begin
            sc_x     <= sc_x - pause_offset;
            sc_mul   <= play_num;
            sc_div   <= play_den;
            sc_start <= 1'b1;
            state    <= S_WAIT_MT;
          end
        end
        S_WAIT_MT: begin
          if (sc_done) begin
            if (reanchor) begin
              sc_x     <= sc_result;
              sc_mul   <= new_den;
              sc_div   <= new_num;
              sc_start <= 1'b1;
              state    <= S_WAIT_RA;
            end else begin
              media <= sc_result;
              state <= S_OUT;
            end
          end
        end
        // Re-anchor the epoch for the new rate, then recompute media time
        S_WAIT_RA: begin
          if (sc_done) begin
            epoch        <= r_now - sc_result;
            pause_offset <= '0;
            play_num     <= new_num;
            play_den     <= new_den;
            reanchor     <= 1'b0;
            state        <= S_ELAP0;
          end
        end
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res_data.run_state_out    <= run_state;
            res_data.media_time_usec  <= media;
            res_data.seek_target_out  <= seek_target;
            res_data.audio_frames_out <= audio_pos;
            res_valid                 <= 1'b1;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/mbc_scale.sv
// Bit-serial scaler: signed x * mul / div, truncated toward zero, saturated to 64 bits.
// Shift-add multiply one multiplier bit per cycle, then restoring divide one bit per cycle.
// Depends on mbc_pkg.
module mbc_scale #(
  parameter int RATE_WIDTH = mbc_pkg::RATE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           x,
  input  logic [RATE_WIDTH-1:0] mul,
  input  logic [RATE_WIDTH-1:0] div,
  output logic                  done,
  output logic [63:0]           result
);

  localparam int PW = 64 + RATE_WIDTH;
  localparam int CW = $clog2(PW);
  localparam logic [63:0] SIGN64 = {1'b1, 63'd0};
  localparam logic [63:0] MASK63 = {1'b0, {63{1'b1}}};

  typedef enum logic [2:0] {S_IDLE, S_NEG, S_MUL, S_DIV, S_SAT} state_t;

  state_t                state;
  logic                  neg;
  logic [63:0]           mag;
  logic [RATE_WIDTH-1:0] mreg;
  logic [RATE_WIDTH-1:0] dreg;
  logic [PW-1:0]         prod;
  logic [RATE_WIDTH-1:0] rem;
  logic [CW-1:0]         cnt;

  // Trial subtract of one restoring-divide step
  logic [RATE_WIDTH:0]   trial;
  logic [RATE_WIDTH:0]   diff;
  logic                  ge;
  // Saturation of the finished quotient
  logic                  hi_set;
  logic [63:0]           lo;
  logic [63:0]           sat;

  assign trial  = {rem, prod[PW-1]};
  assign diff   = trial - {1'b0, dreg};
  assign ge     = (trial >= {1'b0, dreg});
  assign hi_set = |prod[PW-1:64];
  assign lo     = prod[63:0];

  always_comb begin
    if (neg) begin
      sat = (hi_set || (lo > SIGN64)) ? SIGN64 : (~lo + 64'd1);
    end else begin
      sat = (hi_set || lo[63]) ? MASK63 : lo;
    end
  end

  // Sequence negate, multiply, divide and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            mag   <= x;
            neg   <= x[63];
            mreg  <= mul;
            dreg  <= div;
            state <= S_NEG;
          end
        end
        S_NEG: begin
          if (neg) begin
            mag <= ~mag + 64'd1;
          end
          prod  <= '0;
          cnt   <= CW'(RATE_WIDTH - 1);
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= {prod[PW-2:0], 1'b0} + (mreg[RATE_WIDTH-1] ? PW'(mag) : '0);
          mreg <= {mreg[RATE_WIDTH-2:0], 1'b0};
          if (cnt == '0) begin
            rem   <= '0;
            cnt   <= CW'(PW - 1);
            state <= S_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV: begin
          prod <= {prod[PW-2:0], ge};
          rem  <= ge ? diff[RATE_WIDTH-1:0] : trial[RATE_WIDTH-1:0];
          if (cnt == '0) begin
            state <= S_SAT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_SAT: begin
          result <= sat;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/mbc_checker.sv
// Port-level checks for the media playback clock, bound to the top level.
// Tracks requests in flight from the handshakes. Depends on mbc_pkg.
module mbc_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input mbc_pkg::mbc_req_t cmd_data,
  input logic              res_valid,
  input logic              res_stall,
  input mbc_pkg::mbc_res_t res_data
);

  logic       cmd_take;
  logic       res_take;
  logic [1:0] pending;

  assign cmd_take = cmd_valid && !cmd_stall;
  assign res_take = res_valid && !res_stall;

  // Count requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (cmd_take && !res_take) begin
      pending <= pending + 2'd1;
    end else if (res_take && !cmd_take) begin
      pending <= pending - 2'd1;
    end
  end

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // Stopped clock reports zero media time
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.run_state_out == mbc_pkg::RUN_STOPPED)
      |-> (res_data.media_time_usec == 64'sd0))
    else $error("nonzero media time while stopped");

  // No result without a request behind it
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (pending != 2'd0))
    else $error("result without pending request");

  // At most one request in work and one result waiting
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many requests in flight");

  // An accepted request carries a known command code
  a_cmd_known: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> !$isunknown(cmd_data.cmd))
    else $error("unknown command code accepted");

endmodule

bind media_playback_clock mbc_checker u_mbc_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for media_playback_clock: directed and random command requests.
// Predicts state and media time per request and checks every result in order.
// Depends on mbc_pkg and media_playback_clock from the src folder.
module testbench;

  localparam logic [62:0] MAX63       = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] POS_CLIP    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_CLIP    = 64'h8000_0000_0000_0000;
  localparam logic [3:0]  CMD_SPARE_LO = 4'd9;
  localparam logic [3:0]  CMD_SPARE_HI = 4'd15;
  localparam int          REQ_TARGET   = 800;
  localparam int          IDLE_PCT     = 29;
  localparam int          HANG_LIMIT   = 5000;
  localparam int          DRAIN_CYCLES = 400;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  mbc_pkg::mbc_req_t cmd_data = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  mbc_pkg::mbc_res_t res_data;

  media_playback_clock dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_data (cmd_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted clock state
  logic [1:0]  run_st;
  logic [63:0] epoch;
  logic [63:0] pause_accum;
  logic [63:0] pause_mark;
  logic [15:0] play_num;
  logic [15:0] play_den;
  logic [63:0] seek_tgt;
  logic [63:0] audio_pos;

  mbc_pkg::mbc_req_t pending[$];
  mbc_pkg::mbc_res_t status_due[$];
  int       reqs_taken = 0;
  int       results_seen = 0;
  int       directed_count = 0;
  int       faults = 0;
  int       clipped = 0;
  int       hang_cycles = 0;
  logic     calm;

  // Suspend idling on both sides for a stretch of the run
  assign calm = (reqs_taken >= 300) && (reqs_taken < 420);

  // Signed x * mul / div, truncated toward zero, clipped to signed 64 bits
  function automatic logic [63:0] rate_scale(logic [63:0] x, logic [15:0] mul,
                                             logic [15:0] div);
    logic [63:0]  mag;
    logic [127:0] quo;
    mag = x[63] ? (~x + 64'd1) : x;
    quo = ({64'd0, mag} * {112'd0, mul}) / {112'd0, div};
    if (x[63]) begin
      if (quo > {64'd0, NEG_CLIP}) begin
        clipped++;
        return NEG_CLIP;
      end
      return ~quo[63:0] + 64'd1;
    end
    if (quo > {64'd0, POS_CLIP}) begin
      clipped++;
      return POS_CLIP;
    end
    return quo[63:0];
  endfunction

  // Media time at a given wall time under the current state
  function automatic logic [63:0] media_at(logic [63:0] now);
    logic [63:0] span;
    if (run_st == mbc_pkg::RUN_STOPPED) return '0;
    if (run_st == mbc_pkg::RUN_PAUSED) span = pause_mark - epoch - pause_accum;
    else span = now - epoch - pause_accum;
    return rate_scale(span, play_num, play_den);
  endfunction

  // Apply one request to the predicted state and form its status
  function automatic mbc_pkg::mbc_res_t play_clock_step(mbc_pkg::mbc_req_t r);
    logic [63:0]       now;
    logic [63:0]       cur;
    mbc_pkg::mbc_res_t o;
    now = {1'b0, r.now_usec};
    case (r.cmd)
      mbc_pkg::CMD_PLAY: begin
        epoch = now;
        pause_accum = '0;
        pause_mark = '0;
        audio_pos = '0;
        run_st = mbc_pkg::RUN_PLAYING;
      end
      mbc_pkg::CMD_PAUSE: begin
        if (run_st == mbc_pkg::RUN_PLAYING) begin
          pause_mark = now;
          run_st = mbc_pkg::RUN_PAUSED;
        end
      end
      mbc_pkg::CMD_RESUME: begin
        if (run_st == mbc_pkg::RUN_PAUSED) begin
          pause_accum = pause_accum + (now - pause_mark);
          pause_mark = '0;
          run_st = mbc_pkg::RUN_PLAYING;
        end
      end
      mbc_pkg::CMD_STOP: run_st = mbc_pkg::RUN_STOPPED;
      mbc_pkg::CMD_SEEK: begin
        seek_tgt = {1'b0, r.seek_target_in};
        run_st = mbc_pkg::RUN_SEEKING;
      end
      mbc_pkg::CMD_SEEK_DONE: begin
        epoch = now - seek_tgt;
        pause_accum = '0;
        run_st = mbc_pkg::RUN_PLAYING;
      end
      mbc_pkg::CMD_SET_RATE: begin
        // A zero operand leaves the rate and the epoch alone
        if (r.rate_num_in != '0 && r.rate_den_in != '0) begin
          if (run_st == mbc_pkg::RUN_PLAYING) begin
            cur = media_at(now);
            epoch = now - rate_scale(cur, r.rate_den_in, r.rate_num_in);
            pause_accum = '0;
          end
          play_num = r.rate_num_in;
          play_den = r.rate_den_in;
        end
      end
      mbc_pkg::CMD_SET_AUDIO: audio_pos = {1'b0, r.audio_frames_in};
      default: ;
    endcase
    o.run_state_out = run_st;
    o.media_time_usec = media_at(now);
    o.seek_target_out = seek_tgt[62:0];
    o.audio_frames_out = audio_pos[62:0];
    return o;
  endfunction

  function automatic logic [62:0] any_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[62:0];
  endfunction

  task automatic plan_request(input logic [3:0] op, input logic [62:0] now,
                              input logic [62:0] tgt, input logic [15:0] num,
                              input logic [15:0] den, input logic [62:0] frames);
    mbc_pkg::mbc_req_t r;
    r.cmd = op;
    r.now_usec = now;
    r.seek_target_in = tgt;
    r.rate_num_in = num;
    r.rate_den_in = den;
    r.audio_frames_in = frames;
    pending.push_back(r);
  endtask

  task automatic flag_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= 10)
        $display("result %0d: %s expected %h got %h", results_seen, name, want, got);
    end
  endtask

  // Driver: present requests from the pending queue with random gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        status_due.push_back(play_clock_step(cmd_data));
        reqs_taken++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cmd_valid <= 1'b1;
          cmd_data <= pending.pop_front();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall results at random and check each accepted one
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      if (res_valid && !res_stall) begin
        results_seen++;
        if (status_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("result %0d arrived with no request pending", results_seen);
        end else begin
          mbc_pkg::mbc_res_t want;
          want = status_due.pop_front();
          flag_field("run_state_out", {62'd0, want.run_state_out}, {62'd0, res_data.run_state_out});
          flag_field("media_time_usec", want.media_time_usec, res_data.media_time_usec);
          flag_field("seek_target_out", {1'b0, want.seek_target_out},
                     {1'b0, res_data.seek_target_out});
          flag_field("audio_frames_out", {1'b0, want.audio_frames_out},
                     {1'b0, res_data.audio_frames_out});
        end
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", HANG_LIMIT);
      $display("media_playback_clock verification failed");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  initial begin
    logic [62:0] wall;
    logic [3:0]  op;
    logic [15:0] num;
    logic [15:0] den;
    logic [62:0] tgt;
    logic [62:0] frames;
    int          pick;

    run_st = mbc_pkg::RUN_STOPPED;
    epoch = '0;
    pause_accum = '0;
    pause_mark = '0;
    play_num = 16'(mbc_pkg::RATE_RESET);
    play_den = 16'(mbc_pkg::RATE_RESET);
    seek_tgt = '0;
    audio_pos = '0;

    // Directed: field extremes, every command, ignored and saturating cases
    plan_request(mbc_pkg::CMD_QUERY, 63'd0, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_PLAY, 63'd1000, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_QUERY, 63'd2500, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_SET_AUDIO, 63'd2600, '0, '0, '0, MAX63);
    plan_request(mbc_pkg::CMD_PAUSE, 63'd3000, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_PAUSE, 63'd3100, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_QUERY, 63'd5000, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_RESUME, 63'd6000, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_SET_RATE, 63'd6500, '0, 16'd0, 16'd5, '0);
    plan_request(mbc_pkg::CMD_SET_RATE, 63'd7000, '0, 16'hFFFF, 16'd1, '0);
    plan_request(mbc_pkg::CMD_QUERY, MAX63, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_SET_RATE, 63'd7500, '0, 16'd1, 16'hFFFF, '0);
    plan_request(mbc_pkg::CMD_SEEK, 63'd8000, MAX63, '0, '0, '0);
    plan_request(mbc_pkg::CMD_QUERY, 63'd9000, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_SEEK_DONE, 63'd10000, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_SET_RATE, 63'd10001, '0, 16'hFFFF, 16'd1, '0);
    plan_request(mbc_pkg::CMD_RESUME, 63'd10002, '0, '0, '0, '0);
    plan_request(CMD_SPARE_HI, 63'd10003, '0, '0, '0, '0);
    plan_request(CMD_SPARE_LO, 63'd10004, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_STOP, 63'd10005, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_QUERY, 63'd20000, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_SET_RATE, 63'd20001, '0, 16'd7, 16'd0, '0);
    plan_request(mbc_pkg::CMD_PLAY, MAX63, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_QUERY, 63'd0, '0, '0, '0, '0);
    plan_request(mbc_pkg::CMD_SET_RATE, 63'd1, '0, 16'd1, 16'd1, '0);
    directed_count = pending.size();

    // Random: mostly commands on an advancing wall clock, some pure noise
    wall = 63'd5_000_000;
    while (pending.size() < REQ_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        plan_request(4'($urandom_range(15)), any_time(), any_time(), 16'($urandom),
                     16'($urandom), any_time());
      end else begin
        if (pick < 13) wall = any_time();
        else if (pick < 50) wall = wall + 63'($urandom_range(50));
        else wall = wall + 63'($urandom_range(2_000_000));
        pick = $urandom_range(99);
        if (pick < 18) op = mbc_pkg::CMD_QUERY;
        else if (pick < 30) op = mbc_pkg::CMD_PLAY;
        else if (pick < 42) op = mbc_pkg::CMD_PAUSE;
        else if (pick < 54) op = mbc_pkg::CMD_RESUME;
        else if (pick < 60) op = mbc_pkg::CMD_STOP;
        else if (pick < 68) op = mbc_pkg::CMD_SEEK;
        else if (pick < 76) op = mbc_pkg::CMD_SEEK_DONE;
        else if (pick < 90) op = mbc_pkg::CMD_SET_RATE;
        else op = mbc_pkg::CMD_SET_AUDIO;
        pick = $urandom_range(99);
        if (pick < 5) begin
          num = (pick < 2) ? 16'd0 : 16'($urandom_range(1, 65535));
          den = (pick < 2) ? 16'($urandom_range(65535)) : 16'd0;
        end else if (pick < 60) begin
          num = 16'($urandom_range(250, 4000));
          den = 16'($urandom_range(250, 4000));
        end else begin
          num = 16'($urandom_range(1, 65535));
          den = 16'($urandom_range(1, 65535));
        end
        tgt = ($urandom_range(9) == 0) ? any_time() : 63'($urandom_range(300_000_000));
        frames = ($urandom_range(3) == 0) ? any_time() : 63'($urandom_range(1_000_000));
        plan_request(op, wall, tgt, num, den, frames);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests taken, all results back, then a quiet spell
    while (pending.size() != 0 || cmd_valid) @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed) and checked %0d results", reqs_taken,
             directed_count, results_seen);
    $display("%0d scaling steps clipped, %0d mismatches", clipped, faults);
    if (faults == 0 && status_due.size() == 0) begin
      $display("media_playback_clock verification clean");
    end else begin
      $display("media_playback_clock verification failed");
    end
    $finish;
  end

endmodule
